// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CHK_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/core/i2cms_pkg.sv
// Types and constants of the I2C master sequence engine.
package i2cms_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_GO    = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 4;

  typedef enum logic [1:0] {
    ITEM_LOAD,
    ITEM_GO,
    ITEM_EVENT
  } item_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ACK_PREP,
    PH_CHECK,
    PH_GOT_DATA,
    PH_STOP_PREP,
    PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    CMD_START     = 4'd0,
    CMD_DUMMY     = 4'd1,
    CMD_TX_BYTE   = 4'd2,
    CMD_RX_BYTE   = 4'd3,
    CMD_RX_ACK    = 4'd4,
    CMD_DELIVER   = 4'd5,
    CMD_SEND_ACK  = 4'd6,
    CMD_SEND_NACK = 4'd7,
    CMD_STOP_PREP = 4'd8,
    CMD_STOP      = 4'd9
  } cmd_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [1:0]  entry_kind;
    logic [7:0]  entry_byte;
    logic [6:0]  length;
    logic        wake_request;
    logic [7:0]  shift_in;
  } item_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  data;
    logic        wake;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/i2c_master_sequence_engine_unit.sv
// An accepted transaction passes through the front-end queue and then the result buffer
// before its first result shows. The front end takes one input transaction per cycle
// while its queue has room; results leave at one per cycle while m_tready is high, and
// an item that yields two results fills two buffer slots. The back end takes an item only
// while at most two results wait in its buffer. Reset clears state machine, indexes and
// queues; command store content is kept undefined until loaded.
module i2c_master_sequence_engine_unit import i2cms_pkg::*; #(
  parameter int SEQ_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_byte[7:0], length[14:8], wake_request[15], shift_in[23:16]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op[1:0], entry_kind[3:2]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // data[7:0], wake[8], zero pad[15:9]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // command[3:0]
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  i2cms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready)
  );

  i2cms_back #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/core/i2cms_front.sv
// Front end: accepts input transactions, classifies them and queues them; transactions with an unknown op are dropped.
module i2cms_front import i2cms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // entry_byte[7:0], length[14:8], wake_request[15], shift_in[23:16]
  input  logic [IN_DATA_W-1:0] s_tdata,
  // op[1:0], entry_kind[3:2]
  input  logic [IN_USER_W-1:0] s_tuser,
  output item_t                q_item,
  output logic                 q_valid,
  input  logic                 q_ready
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  item_t      cls;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    cls.entry_kind   = s_tuser[3:2];
    cls.entry_byte   = s_tdata[7:0];
    cls.length       = s_tdata[14:8];
    cls.wake_request = s_tdata[15];
    cls.shift_in     = s_tdata[23:16];
    cls.kind         = ITEM_LOAD;
    keep             = 1'b1;
    unique case (s_tuser[1:0])
      OP_LOAD:  cls.kind = ITEM_LOAD;
      OP_GO:    cls.kind = ITEM_GO;
      OP_EVENT: cls.kind = ITEM_EVENT;
      default:  keep = 1'b0;
    endcase
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slots[rp];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/i2cms_back.sv
// Back end: command store, sequencing state machine and result buffer.
module i2cms_back import i2cms_pkg::*; #(
  parameter int SEQ_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 q_item,
  input  logic                  q_valid,
  output logic                  q_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  localparam int IDX_W = $clog2(SEQ_DEPTH);
  localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEQ_DEPTH - 1);

  logic [9:0]       store [SEQ_DEPTH];
  logic [9:0]       rd_q;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] load_index, load_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic             wake_flag, wake_flag_next;
  logic             mem_we;

  res_t             obuf [4];
  logic [1:0]       owp;
  logic [1:0]       orp;
  logic [2:0]       ocnt;
  logic             opop;

  res_t             r0, r1;
  logic [1:0]       n_res;
  logic             take;

  res_t             ne_res;
  phase_t           ne_phase;
  logic             ne_adv;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_sat;

  assign q_ready = (ocnt <= 3'd2);
  assign take    = q_valid && q_ready;

  assign len_ext = CMP_W'(q_item.length);
  assign len_sat = (len_ext > CMP_W'(SEQ_DEPTH)) ? CMP_W'(SEQ_DEPTH) : len_ext;

  // next entry of the run, or the stop when the run is used up
  always_comb begin
    ne_res   = '{command: CMD_STOP_PREP, data: BYTE_ZERO, wake: 1'b0, last: 1'b0};
    ne_phase = PH_STOP;
    ne_adv   = 1'b0;
    if (remaining != '0) begin
      ne_adv = 1'b1;
      case (rd_q[9:8])
        KIND_RESTART: begin
          ne_res   = '{command: CMD_DUMMY, data: BYTE_ONES, wake: 1'b0, last: 1'b0};
          ne_phase = PH_START;
        end
        KIND_READ: begin
          ne_res   = '{command: CMD_RX_BYTE, data: BYTE_ZERO, wake: 1'b0, last: 1'b0};
          ne_phase = PH_GOT_DATA;
        end
        default: begin
          ne_res   = '{command: CMD_TX_BYTE, data: rd_q[7:0], wake: 1'b0, last: 1'b0};
          ne_phase = PH_ACK_PREP;
        end
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    load_index_next = load_index;
    read_index_next = read_index;
    remaining_next  = remaining;
    wake_flag_next  = wake_flag;
    mem_we          = 1'b0;
    n_res           = 2'd0;
    r0              = '{command: CMD_START, data: BYTE_ZERO, wake: 1'b0, last: 1'b0};
    r1              = r0;
    if (take) begin
      unique case (q_item.kind)
        ITEM_LOAD: begin
          if (phase == PH_IDLE) begin
            mem_we          = 1'b1;
            load_index_next = (load_index == IDX_LAST) ? '0 : load_index + 1'b1;
          end
        end
        ITEM_GO: begin
          if (phase == PH_IDLE) begin
            remaining_next  = CNT_W'(len_sat);
            read_index_next = '0;
            load_index_next = '0;
            wake_flag_next  = q_item.wake_request;
            phase_next      = PH_START;
          end
        end
        ITEM_EVENT: begin
          unique case (phase)
            PH_START: begin
              r1         = ne_res;
              n_res      = 2'd2;
              phase_next = ne_phase;
            end
            PH_ACK_PREP: begin
              r0.command = CMD_RX_ACK;
              n_res      = 2'd1;
              phase_next = PH_CHECK;
            end
            PH_CHECK: begin
              n_res = 2'd1;
              if (q_item.shift_in[0]) begin
                r0.command = CMD_STOP_PREP;
                phase_next = PH_STOP;
              end else begin
                r0         = ne_res;
                phase_next = ne_phase;
              end
            end
            PH_GOT_DATA: begin
              r0.command = CMD_DELIVER;
              r0.data    = q_item.shift_in;
              n_res      = 2'd2;
              if (remaining != '0) begin
                r1.command = CMD_SEND_ACK;
                phase_next = PH_CHECK;
              end else begin
                r1.command = CMD_SEND_NACK;
                r1.data    = BYTE_ONES;
                phase_next = PH_STOP_PREP;
              end
            end
            PH_STOP_PREP: begin
              r0.command = CMD_STOP_PREP;
              n_res      = 2'd1;
              phase_next = PH_STOP;
            end
            PH_STOP: begin
              r0.command = CMD_STOP;
              r0.data    = BYTE_ONES;
              r0.wake    = wake_flag;
              n_res      = 2'd1;
              phase_next = PH_IDLE;
            end
            default: ;
          endcase
          // the entry is consumed only where the next-entry path was taken
          if ((phase == PH_START) ||
              ((phase == PH_CHECK) && !q_item.shift_in[0])) begin
            if (ne_adv) begin
              read_index_next = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
              remaining_next  = remaining - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (n_res == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[load_index] <= {q_item.entry_kind, q_item.entry_byte};
    end
    rd_q <= store[read_index_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      load_index <= '0;
      read_index <= '0;
      remaining  <= '0;
      wake_flag  <= 1'b0;
    end else begin
      phase      <= phase_next;
      load_index <= load_index_next;
      read_index <= read_index_next;
      remaining  <= remaining_next;
      wake_flag  <= wake_flag_next;
    end
  end

  assign m_tvalid = (ocnt != 3'd0);
  assign opop     = m_tvalid && m_tready;
  assign m_tdata  = {7'd0, obuf[orp].wake, obuf[orp].data};
  assign m_tuser  = obuf[orp].command;
  assign m_tlast  = obuf[orp].last;

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      obuf[owp] <= r0;
    end
    if (n_res == 2'd2) begin
      obuf[owp + 2'd1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 2'd0;
      orp  <= 2'd0;
      ocnt <= 3'd0;
    end else begin
      owp <= owp + n_res;
      if (opop) begin
        orp <= orp + 2'd1;
      end
      ocnt <= ocnt + {1'b0, n_res} - {2'b0, opop};
    end
  end

endmodule

// File: rtl/core/i2cms_checker.sv
// Port-level checker for the I2C master sequence engine, bound to the top level.
`include "assert_macros.svh"

module i2cms_checker import i2cms_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser,
  input logic                  m_tlast
);

  `CHK_PROP(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
  `CHK_NEVER(a_wake, clk, rst, m_tvalid && m_tdata[8] && (m_tuser != CMD_STOP), "wake outside stop")
  `CHK_NEVER(a_deliver, clk, rst, m_tvalid && (m_tuser == CMD_DELIVER) && m_tlast, "deliver marked last")
  `CHK_NEVER(a_stop, clk, rst, m_tvalid && (m_tuser == CMD_STOP) && !m_tlast, "stop not marked last")

endmodule

bind i2c_master_sequence_engine_unit i2cms_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
